// ----- rtl/drsm_pkg.sv -----
package drsm_pkg;

  // FIFO geometry. Indices run modulo twice the depth so that full and empty differ.
  localparam int FIFO_DEPTH = 8192;
  localparam int ADDR_W     = $clog2(FIFO_DEPTH);
  localparam int IDX_W      = ADDR_W + 1;

  // Field widths.
  localparam int SAMPLE_W   = 16;
  localparam int FRAME_W    = 2 * SAMPLE_W;
  localparam int MODE_W     = 3;
  localparam int VOL_W      = 9;
  localparam int CAP_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // Register reset values.
  localparam logic [VOL_W-1:0] VOL_RESET = 9'd256;
  localparam logic [CAP_W-1:0] CAP_RESET = 14'd3840;

  // Mixing mode codes. Every other code selects split.
  localparam logic [1:0] MIX_SOLO = 2'd0;
  localparam logic [1:0] MIX_SUM  = 2'd1;

  // Input operation codes.
  typedef enum logic [MODE_W-1:0] {
    OP_PUSH_A = 3'd0,
    OP_PUSH_B = 3'd1,
    OP_PULL   = 3'd2,
    OP_TRIM   = 3'd3,
    OP_FLUSH  = 3'd4
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIX_MODE    = 3'd0,
    CFG_FOCUS       = 3'd1,
    CFG_VOLUME_A    = 3'd2,
    CFG_VOLUME_B    = 3'd3,
    CFG_LATENCY_CAP = 3'd4
  } cfg_idx_t;

  // Sequencer states for a pull.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM
  } state_t;

  // How the popped frames are combined.
  typedef enum logic [1:0] {
    KIND_SINGLE,
    KIND_SUM,
    KIND_SPLIT
  } kind_t;

  typedef struct packed {
    logic [MODE_W-1:0]          mode;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } out_t;

endpackage

// ----- rtl/dual_ring_stereo_mixer.sv -----
// Two stereo frame FIFOs, A and B, each 8192 frames deep in its own synchronous
// RAM, feed one stereo output. Push, trim, flush and ignored codes leave the
// sequencer idle, and the next transaction is accepted in the following cycle.
// A pull that finds a frame goes through three steps: the RAM read, the volume
// multipliers, and the sum, shift by 8 and 16-bit saturation; the result then
// sits in an output register, and a further pull waits in its sum step only
// while that register is still full and not being read. A pull that finds no
// frame completes with no result. Configuration writes are accepted at any time
// but must only be made while the block is idle.
module dual_ring_stereo_mixer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  drsm_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output drsm_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [drsm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [drsm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import drsm_pkg::*;

  localparam int OPND_W = SAMPLE_W + 1;
  localparam int GAIN_W = VOL_W + 1;
  localparam int PROD_W = OPND_W + GAIN_W;
  localparam int SUM_W  = PROD_W + 1;

  // Configuration registers.
  logic [1:0]       mix_mode;
  logic             focus;
  logic [VOL_W-1:0] vol_a;
  logic [VOL_W-1:0] vol_b;
  logic [CAP_W-1:0] cap;

  // FIFO control state.
  logic [IDX_W-1:0] wi_a, ri_a, wi_b, ri_b;
  logic [IDX_W-1:0] wi_a_next, ri_a_next, wi_b_next, ri_b_next;
  logic [1:0]       present, present_next;

  // Sequencer and pull context.
  state_t state, state_next;
  kind_t  kind, kind_next;
  logic   play, play_next;
  logic   go_pull;
  logic   load_out;

  // RAM ports.
  logic               we_a, we_b;
  logic [FRAME_W-1:0] wdata;
  logic [FRAME_W-1:0] rdata_a, rdata_b;

  // Decoded view of the current FIFO state.
  logic [IDX_W-1:0] fill_a, fill_b;
  logic             single, play_a;
  logic             trim_a, trim_b;
  logic [IDX_W-1:0] trim_ra, trim_rb;

  // Multiplier operands and products.
  logic signed [OPND_W-1:0] al, ar, bl, br, mono_a, mono_b;
  logic signed [OPND_W-1:0] xl0, xl1, xr0, xr1;
  logic signed [GAIN_W-1:0] gva, gvb, gl0, gl1, gr0, gr1;
  logic signed [PROD_W-1:0] pl0, pl1, pr0, pr1;
  logic signed [SUM_W-1:0]  sum_l, sum_r;

  // Arithmetic shift right by 8, then clamp to the 16-bit sample range.
  function automatic logic [SAMPLE_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] s;
    s = v >>> 8;
    if (s > SUM_W'(32767)) begin
      sat16 = 16'h7fff;
    end else if (s < -SUM_W'(32768)) begin
      sat16 = 16'h8000;
    end else begin
      sat16 = s[SAMPLE_W-1:0];
    end
  endfunction

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_mode <= MIX_SOLO;
      focus    <= 1'b0;
      vol_a    <= VOL_RESET;
      vol_b    <= VOL_RESET;
      cap      <= CAP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MIX_MODE:    mix_mode <= cfg_data[1:0];
        CFG_FOCUS:       focus    <= cfg_data[0];
        CFG_VOLUME_A:    vol_a    <= cfg_data[VOL_W-1:0];
        CFG_VOLUME_B:    vol_b    <= cfg_data[VOL_W-1:0];
        CFG_LATENCY_CAP: cap      <= cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Fill levels, source selection and trim targets.
  assign fill_a  = wi_a - ri_a;
  assign fill_b  = wi_b - ri_b;
  assign single  = (mix_mode == MIX_SOLO) || !present[0] || !present[1];
  assign play_a  = (mix_mode == MIX_SOLO) ? !focus : present[0];
  assign trim_a  = 32'(fill_a) > 32'(cap);
  assign trim_b  = 32'(fill_b) > 32'(cap);
  assign trim_ra = wi_a - IDX_W'(cap);
  assign trim_rb = wi_b - IDX_W'(cap);
  assign wdata   = {in_data.right_in, in_data.left_in};

  // Index updates and RAM controls for the accepted transaction.
  always_comb begin
    wi_a_next    = wi_a;
    ri_a_next    = ri_a;
    wi_b_next    = wi_b;
    ri_b_next    = ri_b;
    present_next = present;
    kind_next    = kind;
    play_next    = play;
    we_a         = 1'b0;
    we_b         = 1'b0;
    go_pull      = 1'b0;
    if (in_valid && in_ready) begin
      unique case (in_data.mode)
        OP_PUSH_A: begin
          present_next[0] = 1'b1;
          if (32'(fill_a) < 32'(FIFO_DEPTH)) begin
            we_a      = 1'b1;
            wi_a_next = wi_a + IDX_W'(1);
          end
        end
        OP_PUSH_B: begin
          present_next[1] = 1'b1;
          if (32'(fill_b) < 32'(FIFO_DEPTH)) begin
            we_b      = 1'b1;
            wi_b_next = wi_b + IDX_W'(1);
          end
        end
        OP_FLUSH: begin
          ri_a_next = wi_a;
          ri_b_next = wi_b;
        end
        OP_TRIM: begin
          if (single) begin
            if (play_a) begin
              if (trim_a) begin
                ri_a_next = trim_ra;
              end
              if (mix_mode == MIX_SOLO) begin
                ri_b_next = wi_b;
              end
            end else begin
              if (trim_b) begin
                ri_b_next = trim_rb;
              end
              if (mix_mode == MIX_SOLO) begin
                ri_a_next = wi_a;
              end
            end
          end else begin
            if (trim_a) begin
              ri_a_next = trim_ra;
            end
            if (trim_b) begin
              ri_b_next = trim_rb;
            end
          end
        end
        OP_PULL: begin
          if (single) begin
            kind_next = KIND_SINGLE;
            play_next = play_a;
            if (play_a) begin
              if (mix_mode == MIX_SOLO) begin
                ri_b_next = wi_b;
              end
              if (fill_a != '0) begin
                ri_a_next = ri_a + IDX_W'(1);
                go_pull   = 1'b1;
              end
            end else begin
              if (mix_mode == MIX_SOLO) begin
                ri_a_next = wi_a;
              end
              if (fill_b != '0) begin
                ri_b_next = ri_b + IDX_W'(1);
                go_pull   = 1'b1;
              end
            end
          end else if (fill_a != '0 && fill_b != '0) begin
            kind_next = (mix_mode == MIX_SUM) ? KIND_SUM : KIND_SPLIT;
            ri_a_next = ri_a + IDX_W'(1);
            ri_b_next = ri_b + IDX_W'(1);
            go_pull   = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wi_a    <= '0;
      ri_a    <= '0;
      wi_b    <= '0;
      ri_b    <= '0;
      present <= '0;
      state   <= ST_IDLE;
    end else begin
      wi_a    <= wi_a_next;
      ri_a    <= ri_a_next;
      wi_b    <= wi_b_next;
      ri_b    <= ri_b_next;
      present <= present_next;
      state   <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    kind <= kind_next;
    play <= play_next;
  end

  // Frame stores; the pull reads at the current read index of each FIFO.
  drsm_ram #(.WIDTH(FRAME_W), .DEPTH(FIFO_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (wi_a[ADDR_W-1:0]),
    .wdata (wdata),
    .re    (go_pull),
    .raddr (ri_a[ADDR_W-1:0]),
    .rdata (rdata_a)
  );

  drsm_ram #(.WIDTH(FRAME_W), .DEPTH(FIFO_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (wi_b[ADDR_W-1:0]),
    .wdata (wdata),
    .re    (go_pull),
    .raddr (ri_b[ADDR_W-1:0]),
    .rdata (rdata_b)
  );

  // Next state of the pull sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (go_pull) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_SUM;
      ST_SUM: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_MUL:  ;
      ST_SUM:  load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  // Operand selection from the read frames.
  always_comb begin
    al     = {rdata_a[SAMPLE_W-1], rdata_a[SAMPLE_W-1:0]};
    ar     = {rdata_a[FRAME_W-1], rdata_a[FRAME_W-1:SAMPLE_W]};
    bl     = {rdata_b[SAMPLE_W-1], rdata_b[SAMPLE_W-1:0]};
    br     = {rdata_b[FRAME_W-1], rdata_b[FRAME_W-1:SAMPLE_W]};
    mono_a = (al + ar) >>> 1;
    mono_b = (bl + br) >>> 1;
    gva    = {1'b0, vol_a};
    gvb    = {1'b0, vol_b};
    xl1    = '0;
    xr1    = '0;
    gl1    = '0;
    gr1    = '0;
    unique case (kind)
      KIND_SINGLE: begin
        xl0 = play ? al : bl;
        xr0 = play ? ar : br;
        gl0 = play ? gva : gvb;
        gr0 = gl0;
      end
      KIND_SUM: begin
        xl0 = al;
        xr0 = ar;
        gl0 = gva;
        gr0 = gva;
        xl1 = bl;
        xr1 = br;
        gl1 = gvb;
        gr1 = gvb;
      end
      default: begin
        xl0 = mono_a;
        xr0 = mono_b;
        gl0 = gva;
        gr0 = gvb;
      end
    endcase
  end

  // Volume products, registered before the sum.
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      pl0 <= xl0 * gl0;
      pl1 <= xl1 * gl1;
      pr0 <= xr0 * gr0;
      pr1 <= xr1 * gr1;
    end
  end

  assign sum_l = SUM_W'(pl0) + SUM_W'(pl1);
  assign sum_r = SUM_W'(pr0) + SUM_W'(pr1);

  // Output register holds a finished frame until the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.left_out  <= sat16(sum_l);
      out_data.right_out <= sat16(sum_r);
    end
  end

endmodule

// ----- rtl/drsm_ram.sv -----
module drsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
